### design/mtd_pkg.sv
// Shared types, constants and helpers for the Manchester edge timing decoder.
package mtd_pkg;

    localparam int TICKS_W   = 8;
    localparam int HALF_W    = 7;
    localparam int TOL_W     = 6;
    localparam int WORD_W    = 8;
    localparam int CNT_W     = 4;
    localparam int ONES_W    = 2;
    localparam int MODE_W    = 2;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam int BITS_PER_WORD_DEF = 8;
    localparam int START_ONES_DEF    = 3;

    localparam logic [HALF_W-1:0] HALF_RESET = 7'd7;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 6'd2;

    // register index, taken from paddr[2]
    localparam logic REG_HALF = 1'b0;
    localparam logic REG_TOL  = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAIT  = 2'd0,
        MODE_SYNC  = 2'd1,
        MODE_START = 2'd2,
        MODE_MSG   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [HALF_W-1:0] half_ticks;
        logic [TOL_W-1:0]  tol_ticks;
    } t_cfg;

    // ticks lies within nominal +/- tol, lower bound clamped at zero
    function automatic logic in_window(input logic [TICKS_W-1:0] ticks,
                                       input logic [TICKS_W-1:0] nominal,
                                       input logic [TOL_W-1:0]   tol);
        logic [TICKS_W:0] lo_sum;
        logic [TICKS_W:0] hi_sum;
        lo_sum = {1'b0, ticks} + {{(TICKS_W+1-TOL_W){1'b0}}, tol};
        hi_sum = {1'b0, nominal} + {{(TICKS_W+1-TOL_W){1'b0}}, tol};
        return (lo_sum >= {1'b0, nominal}) && ({1'b0, ticks} <= hi_sum);
    endfunction

endpackage

### design/mtd_apb_regs.sv
// APB configuration registers: half period and tolerance.
module mtd_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtd_pkg::APB_AW-1:0]    paddr,
    input  logic [mtd_pkg::APB_DW-1:0]    pwdata,
    output logic [mtd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output mtd_pkg::t_cfg                 o_cfg
);

    logic [mtd_pkg::HALF_W-1:0] r_half;
    logic [mtd_pkg::TOL_W-1:0]  r_tol;
    logic                       wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= mtd_pkg::HALF_RESET;
            r_tol  <= mtd_pkg::TOL_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                mtd_pkg::REG_HALF: r_half <= pwdata[mtd_pkg::HALF_W-1:0];
                mtd_pkg::REG_TOL:  r_tol  <= pwdata[mtd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mtd_pkg::REG_HALF: prdata = {{(mtd_pkg::APB_DW-mtd_pkg::HALF_W){1'b0}}, r_half};
            mtd_pkg::REG_TOL:  prdata = {{(mtd_pkg::APB_DW-mtd_pkg::TOL_W){1'b0}}, r_tol};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.half_ticks = r_half;
    assign o_cfg.tol_ticks  = r_tol;

endmodule

### design/mtd_core.sv
// Edge classifier, bit decoder and word assembler with input and result registers.
module mtd_core #(
    parameter int BITS_PER_WORD = mtd_pkg::BITS_PER_WORD_DEF,
    parameter int START_ONES    = mtd_pkg::START_ONES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mtd_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mtd_pkg::TICKS_W-1:0]   i_interval_ticks,
    input  logic                          i_pin_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_byte_valid,
    output logic [mtd_pkg::WORD_W-1:0]    o_data_byte,
    output logic                          o_timing_error,
    output logic [mtd_pkg::MODE_W-1:0]    o_receiver_mode
);

    localparam int WORD_SHIFT = mtd_pkg::WORD_W - BITS_PER_WORD;
    localparam logic [mtd_pkg::CNT_W-1:0]  CNT_LAST  = mtd_pkg::CNT_W'(BITS_PER_WORD);
    localparam logic [mtd_pkg::ONES_W-1:0] ONES_LAST = mtd_pkg::ONES_W'(START_ONES);

    // input register
    logic                        r_in_valid;
    logic [mtd_pkg::TICKS_W-1:0] r_in_ticks;
    logic                        r_in_level;

    // decoder state
    mtd_pkg::t_mode              r_mode,   n_mode;
    logic [mtd_pkg::ONES_W-1:0]  r_ones,   n_ones;
    logic [mtd_pkg::WORD_W-1:0]  r_shift,  n_shift;
    logic [mtd_pkg::CNT_W-1:0]   r_cnt,    n_cnt;
    logic                        r_cur,    n_cur;
    logic                        r_half,   n_half;

    // result register
    logic                        r_out_valid;
    logic                        r_out_bvalid, n_out_bvalid;
    logic [mtd_pkg::WORD_W-1:0]  r_out_byte,   n_out_byte;
    logic                        r_out_err,    n_out_err;
    logic [mtd_pkg::MODE_W-1:0]  r_out_mode;

    logic                        advance;
    logic                        in_take;
    logic                        is_half;
    logic                        is_full;
    logic                        take;
    logic                        dbit;
    logic                        err;
    logic [mtd_pkg::WORD_W-1:0]  shift_in;
    logic [mtd_pkg::CNT_W-1:0]   cnt_inc;
    logic [mtd_pkg::ONES_W-1:0]  ones_inc;
    logic                        word_done;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign is_half = mtd_pkg::in_window(r_in_ticks, {1'b0, i_cfg.half_ticks}, i_cfg.tol_ticks);
    assign is_full = mtd_pkg::in_window(r_in_ticks, {i_cfg.half_ticks, 1'b0}, i_cfg.tol_ticks);

    // decode one bit per pair of half intervals or per full interval: T+T repeats, 2T inverts
    always_comb begin
        take = 1'b0;
        dbit = r_cur;
        err  = 1'b0;
        if (r_mode != mtd_pkg::MODE_WAIT) begin
            if (r_half) begin
                if (is_half) take = 1'b1;
                else         err  = 1'b1;
            end else if (!is_half) begin
                if (is_full) begin
                    take = 1'b1;
                    dbit = !r_cur;
                end else begin
                    err = 1'b1;
                end
            end
        end
    end

    assign shift_in  = {dbit, r_shift[mtd_pkg::WORD_W-1:1]};
    assign cnt_inc   = r_cnt + 1'b1;
    assign ones_inc  = r_ones + 1'b1;
    assign word_done = take && (r_mode == mtd_pkg::MODE_MSG) && (cnt_inc >= CNT_LAST);

    // next state
    always_comb begin
        n_mode  = r_mode;
        n_ones  = r_ones;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_cur   = r_cur;
        n_half  = r_half;
        if (r_mode == mtd_pkg::MODE_WAIT) begin
            if (is_full) begin
                n_half = 1'b0;
                n_cur  = r_in_level;
                n_ones = '0;
                n_mode = mtd_pkg::MODE_SYNC;
            end
        end else if (err) begin
            n_mode = mtd_pkg::MODE_WAIT;
        end else if (r_half) begin
            n_half = 1'b0;
        end else if (is_half) begin
            n_half = 1'b1;
        end else begin
            n_cur = dbit;
        end

        if (take) begin
            case (r_mode)
                mtd_pkg::MODE_SYNC: begin
                    if (dbit) begin
                        n_ones = mtd_pkg::ONES_W'(1);
                        if (START_ONES <= 1) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            n_mode  = mtd_pkg::MODE_MSG;
                        end else begin
                            n_mode = mtd_pkg::MODE_START;
                        end
                    end
                end
                mtd_pkg::MODE_START: begin
                    if (dbit) begin
                        n_ones = ones_inc;
                        if (ones_inc >= ONES_LAST) begin
                            n_shift = '0;
                            n_cnt   = '0;
                            n_mode  = mtd_pkg::MODE_MSG;
                        end
                    end else begin
                        n_mode = mtd_pkg::MODE_WAIT;
                    end
                end
                mtd_pkg::MODE_MSG: begin
                    if (word_done) begin
                        n_shift = '0;
                        n_cnt   = '0;
                    end else begin
                        n_shift = shift_in;
                        n_cnt   = cnt_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // result fields
    always_comb begin
        n_out_bvalid = word_done;
        n_out_byte   = word_done ? (shift_in >> WORD_SHIFT) : '0;
        n_out_err    = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= mtd_pkg::MODE_WAIT;
            r_ones      <= '0;
            r_shift     <= '0;
            r_cnt       <= '0;
            r_cur       <= 1'b0;
            r_half      <= 1'b0;
        end else begin
            if (in_take)      r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;

            if (advance)           r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;

            if (advance) begin
                r_mode  <= n_mode;
                r_ones  <= n_ones;
                r_shift <= n_shift;
                r_cnt   <= n_cnt;
                r_cur   <= n_cur;
                r_half  <= n_half;
            end
        end
    end

    // payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ticks <= i_interval_ticks;
            r_in_level <= i_pin_level;
        end
        if (advance) begin
            r_out_bvalid <= n_out_bvalid;
            r_out_byte   <= n_out_byte;
            r_out_err    <= n_out_err;
            r_out_mode   <= n_mode;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_valid    = r_out_bvalid;
    assign o_data_byte     = r_out_byte;
    assign o_timing_error  = r_out_err;
    assign o_receiver_mode = r_out_mode;

    a_byte_in_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bvalid) |-> (r_out_mode == mtd_pkg::MODE_MSG))
        else $error("word delivered outside message mode");

    a_err_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_mode == mtd_pkg::MODE_WAIT))
        else $error("timing error without return to waiting");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_bvalid) |-> (r_out_byte == '0))
        else $error("data byte nonzero without valid word");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_LAST)
        else $error("bit count reached word length");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(advance) && $past(i_rst_n) |-> $stable(r_mode) && $stable(r_cnt))
        else $error("decoder state moved without an edge word");

endmodule

### design/manchester_edge_timing_decoder.sv
// Top level of the Manchester edge timing decoder.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_stall       | i_interval_ticks, i_pin_level
//  output   | o_out_valid / i_out_stall     | o_byte_valid, o_data_byte, o_timing_error,
//           |                               | o_receiver_mode
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One word per edge, one result word per edge, one word per cycle sustained while the output is not stalled.
// Each word passes an input register, then the state update and window
// compares ahead of the result register.
// Reset (i_rst_n low, synchronous) clears decoder state and both valid flags;
// half period returns to 7 ticks, tolerance to 2.
// A stalled output holds its word; the input register fills and then stalls.
module manchester_edge_timing_decoder #(
    parameter int BITS_PER_WORD = mtd_pkg::BITS_PER_WORD_DEF,
    parameter int START_ONES    = mtd_pkg::START_ONES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtd_pkg::APB_AW-1:0]    paddr,
    input  logic [mtd_pkg::APB_DW-1:0]    pwdata,
    output logic [mtd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mtd_pkg::TICKS_W-1:0]   i_interval_ticks,
    input  logic                          i_pin_level,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_byte_valid,
    output logic [mtd_pkg::WORD_W-1:0]    o_data_byte,
    output logic                          o_timing_error,
    output logic [mtd_pkg::MODE_W-1:0]    o_receiver_mode
);

    mtd_pkg::t_cfg cfg;

    mtd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mtd_core #(
        .BITS_PER_WORD (BITS_PER_WORD),
        .START_ONES    (START_ONES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_interval_ticks (i_interval_ticks),
        .i_pin_level      (i_pin_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_byte_valid     (o_byte_valid),
        .o_data_byte      (o_data_byte),
        .o_timing_error   (o_timing_error),
        .o_receiver_mode  (o_receiver_mode)
    );

endmodule
